FILE: hdl/fcch_pkg.sv
// Shared types and constants of the face color class histogram.
package fcch_pkg;

	localparam int MAX_COLORS  = 16;
	localparam int NUM_CLASSES = MAX_COLORS + 1;
	localparam int CLASS_BITS  = 5;
	localparam int COLOR_IDX_BITS = $clog2(MAX_COLORS);
	localparam int FACE_BITS   = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_PIXEL = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] CFG_RADIX  = 2'd0;
	localparam logic [1:0] CFG_COLORS = 2'd1;
	localparam logic [1:0] CFG_FACES  = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_COUNT,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [8:0] radix;
		logic [4:0] colors_in_use;
		logic [8:0] faces_in_use;
	} cfg_t;

	typedef struct packed {
		op_t                   op;
		logic [CLASS_BITS-1:0] color_class;
		logic [FACE_BITS-1:0]  face_index;
		logic                  out_of_range;
	} entry_t;

endpackage

FILE: hdl/face_color_class_histogram.sv
// Items pass stage 1, stage 2, a queue slot, the RAM read and the result register.
// The back end handles one item at a time: RAM read on pop, write back in B_UPDATE.
// The front end takes one item per cycle until the queue between the two fills.
// Reset: registers go to radix 256, no colors in use, 256 faces; the counter RAM is
// zeroed by a pass over MAX_FACES*17 entries (4352 by default) with in_ready held low.
// The color table holds no defined value until loaded.
module face_color_class_histogram #(
	parameter int MAX_FACES  = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [8:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [4:0]  class_index,
	input  logic [7:0]  face_select,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  id_red,
	input  logic [7:0]  id_green,
	input  logic [7:0]  id_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] count_value,
	output logic [4:0]  color_class,
	output logic [23:0] face_index,
	output logic        face_out_of_range
);

	fcch_pkg::cfg_t   cfg_q;
	fcch_pkg::entry_t push_entry;
	fcch_pkg::entry_t head;
	logic             push;
	logic             pop;
	logic             q_not_full;
	logic             q_not_empty;
	logic             clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix         <= 9'd256;
			cfg_q.colors_in_use <= 5'd0;
			cfg_q.faces_in_use  <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				fcch_pkg::CFG_RADIX:  cfg_q.radix         <= cfg_wdata;
				fcch_pkg::CFG_COLORS: cfg_q.colors_in_use <= cfg_wdata[4:0];
				fcch_pkg::CFG_FACES:  cfg_q.faces_in_use  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	fcch_front #(
		.MAX_FACES(MAX_FACES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.enable      (!clearing),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.class_index (class_index),
		.face_select (face_select),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.id_red      (id_red),
		.id_green    (id_green),
		.id_blue     (id_blue),
		.q_ready     (q_not_full),
		.push        (push),
		.entry       (push_entry)
	);

	fcch_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (q_not_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	fcch_back #(
		.MAX_FACES  (MAX_FACES),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_not_empty),
		.head              (head),
		.pop               (pop),
		.clearing          (clearing),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.count_value       (count_value),
		.color_class       (color_class),
		.face_index        (face_index),
		.face_out_of_range (face_out_of_range)
	);

	// nothing reaches the queue while the counters are being cleared
	a_no_push_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push)
		else $error("item queued during counter clear");

	a_empty_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> !q_not_empty)
		else $error("queue not empty when clear ends");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("pop from empty queue");

	a_oor_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && face_out_of_range) |-> (count_value == 32'd0))
		else $error("out-of-range item carries a count");

endmodule

FILE: hdl/fcch_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4352
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/fcch_front.sv
// Front end: accepts items, holds the color table, classifies and decodes face ids.
module fcch_front #(
	parameter int MAX_FACES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fcch_pkg::cfg_t        cfg,
	input  logic                  enable,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [4:0]            class_index,
	input  logic [7:0]            face_select,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [7:0]            id_red,
	input  logic [7:0]            id_green,
	input  logic [7:0]            id_blue,
	input  logic                  q_ready,
	output logic                  push,
	output fcch_pkg::entry_t      entry
);

	localparam int FB = fcch_pkg::FACE_BITS;
	localparam int CB = fcch_pkg::CLASS_BITS;

	logic [23:0] tbl_q [fcch_pkg::MAX_COLORS];

	// stage 1: raw item
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [4:0]  cls_s1;
	logic [7:0]  fsel_s1;
	logic [23:0] color_s1;
	logic [7:0]  id_red_s1;
	logic [7:0]  id_green_s1;
	logic [7:0]  id_blue_s1;

	// stage 2: class and partial face id
	logic        valid_s2;
	logic [1:0]  mode_s2;
	logic [4:0]  cls_s2;
	logic [7:0]  fsel_s2;
	logic [CB-1:0] match_s2;
	logic [15:0] partial_s2;
	logic [7:0]  id_blue_s2;

	logic [8:0]    radix_eff;
	logic [CB-1:0] colors_eff;
	logic [FB-1:0] faces_eff;
	logic          free_s1;
	logic          free_s2;
	logic          adv_s1;
	logic [CB-1:0] match;
	logic [16:0]   partial;
	logic [24:0]   id_full;
	logic [FB-1:0] id;
	logic [FB-1:0] fsel_wide;
	logic          pix_oor;
	logic          read_oor;

	assign radix_eff  = (cfg.radix > 9'd256) ? 9'd256 : cfg.radix;
	assign colors_eff = (cfg.colors_in_use > CB'(fcch_pkg::MAX_COLORS)) ?
		CB'(fcch_pkg::MAX_COLORS) : cfg.colors_in_use;
	assign faces_eff  = (FB'(cfg.faces_in_use) > FB'(MAX_FACES)) ?
		FB'(MAX_FACES) : FB'(cfg.faces_in_use);

	assign push    = valid_s2 && q_ready;
	assign free_s2 = !valid_s2 || q_ready;
	assign free_s1 = !valid_s1 || free_s2;
	assign adv_s1  = valid_s1 && free_s2;
	assign in_ready = free_s1 && enable;

	// lowest matching entry wins
	always_comb begin
		match = CB'(fcch_pkg::MAX_COLORS);
		for (int k = fcch_pkg::MAX_COLORS - 1; k >= 0; k--) begin
			if ((CB'(k) < colors_eff) && (tbl_q[k] == color_s1)) begin
				match = CB'(k);
			end
		end
	end

	assign partial = ({9'd0, id_red_s1} * {8'd0, radix_eff}) + {9'd0, id_green_s1};

	assign id_full   = ({9'd0, partial_s2} * {16'd0, radix_eff}) + {17'd0, id_blue_s2};
	assign id        = id_full[FB-1:0];
	assign fsel_wide = FB'(fsel_s2);
	assign pix_oor   = id >= faces_eff;
	assign read_oor  = (fsel_wide >= faces_eff) || (cls_s2 > CB'(fcch_pkg::MAX_COLORS));

	always_comb begin
		entry = '0;
		case (mode_s2)
			fcch_pkg::MODE_PIXEL: begin
				entry.color_class  = match_s2;
				entry.face_index   = id;
				entry.out_of_range = pix_oor;
				entry.op           = pix_oor ? fcch_pkg::OP_NONE : fcch_pkg::OP_COUNT;
			end
			fcch_pkg::MODE_READ: begin
				entry.color_class  = cls_s2;
				entry.face_index   = fsel_wide;
				entry.out_of_range = read_oor;
				entry.op           = read_oor ? fcch_pkg::OP_NONE : fcch_pkg::OP_READ;
			end
			default: begin
				entry = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= in_valid && in_ready;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1     <= mode;
			cls_s1      <= class_index;
			fsel_s1     <= face_select;
			color_s1    <= {red, green, blue};
			id_red_s1   <= id_red;
			id_green_s1 <= id_green;
			id_blue_s1  <= id_blue;
		end
		if (adv_s1) begin
			mode_s2    <= mode_s1;
			cls_s2     <= cls_s1;
			fsel_s2    <= fsel_s1;
			match_s2   <= match;
			partial_s2 <= partial[15:0];
			id_blue_s2 <= id_blue_s1;
		end
		// load the table as the item leaves stage 1, ahead of any later pixel
		if (adv_s1 && (mode_s1 == fcch_pkg::MODE_LOAD) &&
			(cls_s1 < CB'(fcch_pkg::MAX_COLORS))) begin
			tbl_q[cls_s1[fcch_pkg::COLOR_IDX_BITS-1:0]] <= color_s1;
		end
	end

endmodule

FILE: hdl/fcch_queue.sv
// Short queue of classified items between front end and counter back end.
module fcch_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fcch_pkg::entry_t push_entry,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output fcch_pkg::entry_t head
);

	localparam int QD = fcch_pkg::QUEUE_DEPTH;
	localparam int PB = (QD > 1) ? $clog2(QD) : 1;
	localparam int NB = $clog2(QD + 1);

	fcch_pkg::entry_t slot_q [QD];
	logic [PB-1:0]    wr_ptr_q;
	logic [PB-1:0]    rd_ptr_q;
	logic [NB-1:0]    count_q;

	assign not_full  = count_q != NB'(QD);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

FILE: hdl/fcch_back.sv
// Back end: clears and updates the counter RAM and drives the result register.
module fcch_back #(
	parameter int MAX_FACES  = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  fcch_pkg::entry_t head,
	output logic             pop,
	output logic             clearing,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      count_value,
	output logic [4:0]       color_class,
	output logic [23:0]      face_index,
	output logic             face_out_of_range
);

	localparam int DEPTH = MAX_FACES * fcch_pkg::NUM_CLASSES;
	localparam int AB    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_UPDATE
	} state_t;

	state_t            state_q;
	logic [AB-1:0]     clr_q;
	logic [AB-1:0]     addr_q;
	fcch_pkg::entry_t  ent_q;

	logic                  out_free;
	logic [AB-1:0]         head_addr;
	logic                  ram_we;
	logic [AB-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] bumped;
	logic [COUNT_BITS-1:0] result;

	assign out_free  = !out_valid || out_ready;
	assign clearing  = state_q == B_CLEAR;
	assign pop       = (state_q == B_IDLE) && q_valid;
	assign head_addr = (AB'(head.face_index) * AB'(fcch_pkg::NUM_CLASSES)) +
		AB'(head.color_class);

	// hold at all ones
	assign bumped = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

	always_comb begin
		case (ent_q.op)
			fcch_pkg::OP_COUNT: result = bumped;
			fcch_pkg::OP_READ:  result = ram_rdata;
			default:            result = '0;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = bumped;
		if (state_q == B_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if ((state_q == B_UPDATE) && out_free &&
			(ent_q.op == fcch_pkg::OP_COUNT)) begin
			ram_we = 1'b1;
		end
	end

	fcch_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_counters (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop),
		.raddr (head_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if ((state_q == B_UPDATE) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AB'(DEPTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_UPDATE;
					end
				end
				B_UPDATE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q  <= head;
			addr_q <= head_addr;
		end
		if ((state_q == B_UPDATE) && out_free) begin
			count_value       <= 32'(result);
			color_class       <= ent_q.color_class;
			face_index        <= ent_q.face_index;
			face_out_of_range <= ent_q.out_of_range;
		end
	end

endmodule

FILE: bench/face_color_class_histogram_tb.sv
// Self-checking bench for the face color class histogram: directed and random items.
`timescale 1ns / 1ps

module face_color_class_histogram_tb;

	localparam int          FACE_CAP    = 256;
	localparam int          CYCLE_LIMIT = 300000;
	localparam logic [1:0]  MODE_NONE   = 2'd3;

	typedef struct packed {
		logic [31:0] count;
		logic [4:0]  cls;
		logic [23:0] face;
		logic        oor;
	} tally_result_t;

	// Tracks the color table, the per-face class counters and the results they imply.
	class histogram_tracker;
		logic [8:0]    radix_reg;
		logic [4:0]    colors_reg;
		logic [8:0]    faces_reg;
		logic [23:0]   palette [fcch_pkg::MAX_COLORS];
		logic [31:0]   tally [FACE_CAP * fcch_pkg::NUM_CLASSES];
		tally_result_t pending_tallies [$];
		int            errors;

		function new();
			radix_reg  = 9'd256;
			colors_reg = 5'd0;
			faces_reg  = 9'd256;
			foreach (palette[k]) palette[k] = '0;
			foreach (tally[k]) tally[k] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] addr, logic [8:0] data);
			case (addr)
				fcch_pkg::CFG_RADIX:  radix_reg  = data;
				fcch_pkg::CFG_COLORS: colors_reg = data[4:0];
				fcch_pkg::CFG_FACES:  faces_reg  = data;
				default: ;
			endcase
		endfunction

		function void accept_item(logic [1:0] m, logic [4:0] ci, logic [7:0] fs,
				logic [23:0] rgb, logic [7:0] ir, logic [7:0] ig, logic [7:0] ib);
			tally_result_t      want;
			longint unsigned    rad_eff, id_full, face_lim, slot;
			int                 n_match, hit;
			want     = '0;
			face_lim = (faces_reg > FACE_CAP) ? FACE_CAP : faces_reg;
			case (m)
				fcch_pkg::MODE_LOAD: begin
					if (ci < fcch_pkg::MAX_COLORS)
						palette[ci] = rgb;
				end
				fcch_pkg::MODE_PIXEL: begin
					n_match = (colors_reg > fcch_pkg::MAX_COLORS) ?
						fcch_pkg::MAX_COLORS : colors_reg;
					hit = fcch_pkg::MAX_COLORS;
					for (int k = 0; k < n_match; k++) begin
						if (palette[k] == rgb) begin
							hit = k;
							break;
						end
					end
					rad_eff = (radix_reg > 256) ? 256 : radix_reg;
					id_full = 64'(ir) * rad_eff * rad_eff + 64'(ig) * rad_eff + 64'(ib);
					want.cls  = 5'(hit);
					want.face = id_full[23:0];
					if (id_full >= face_lim) begin
						want.oor = 1'b1;
					end else begin
						slot = id_full * fcch_pkg::NUM_CLASSES + hit;
						// saturate rather than wrap
						if (tally[slot] != '1)
							tally[slot] = tally[slot] + 1;
						want.count = tally[slot];
					end
				end
				fcch_pkg::MODE_READ: begin
					want.cls  = ci;
					want.face = 24'(fs);
					if (fs >= face_lim || ci > fcch_pkg::MAX_COLORS)
						want.oor = 1'b1;
					else
						want.count = tally[64'(fs) * fcch_pkg::NUM_CLASSES + ci];
				end
				default: ;
			endcase
			pending_tallies = {pending_tallies, want};
		endfunction

		function void flag_field(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [31:0] count, logic [4:0] cls, logic [23:0] face,
				logic oor);
			tally_result_t want;
			if (pending_tallies.size() == 0) begin
				$display("%0t: unexpected result, actual count %0d class %0d face %0d flag %0b",
					$time, count, cls, face, oor);
				errors++;
				return;
			end
			want = pending_tallies.pop_front();
			flag_field("count_value", want.count, count);
			flag_field("color_class", want.cls, cls);
			flag_field("face_index", want.face, face);
			flag_field("face_out_of_range", want.oor, oor);
		endfunction

		function bit drained();
			return pending_tallies.size() == 0;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [8:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [4:0]  class_index;
	logic [7:0]  face_select;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  id_red;
	logic [7:0]  id_green;
	logic [7:0]  id_blue;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] count_value;
	logic [4:0]  color_class;
	logic [23:0] face_index;
	logic        face_out_of_range;

	histogram_tracker sb = new();
	int               gap_rate;
	int               stall_rate;
	bit               quiet;
	int unsigned      cycle_count;

	face_color_class_histogram #(
		.MAX_FACES  (FACE_CAP),
		.COUNT_BITS (32)
	) u_dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(count_value, color_class, face_index, face_out_of_range);
	end

	// Output side: random stall bursts unless the run is in its quiet tail.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) < stall_rate) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [1:0] addr, input logic [8:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		sb.write_reg(addr, data);
		@(posedge clk);
	endtask

	task automatic set_config(input logic [8:0] rad, input logic [8:0] cols,
			input logic [8:0] fcs);
		write_reg(fcch_pkg::CFG_RADIX, rad);
		write_reg(fcch_pkg::CFG_COLORS, cols);
		write_reg(fcch_pkg::CFG_FACES, fcs);
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(input logic [1:0] m, input logic [4:0] ci, input logic [7:0] fs,
			input logic [23:0] rgb, input logic [7:0] ir, input logic [7:0] ig,
			input logic [7:0] ib);
		if (!quiet && $urandom_range(0, 9) < gap_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		class_index <= ci;
		face_select <= fs;
		{red, green, blue} <= rgb;
		id_red      <= ir;
		id_green    <= ig;
		id_blue     <= ib;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.accept_item(m, ci, fs, rgb, ir, ig, ib);
	endtask

	// Drop valid and hold until every expected result is back.
	task automatic drain();
		in_valid <= 1'b0;
		while (!sb.drained()) @(posedge clk);
	endtask

	task automatic rand_item();
		int          pick;
		logic [1:0]  m;
		logic [4:0]  ci;
		logic [7:0]  fs, ir, ig, ib;
		logic [23:0] rgb;
		pick = $urandom_range(0, 19);
		ci   = 5'($urandom);
		fs   = 8'($urandom);
		rgb  = 24'($urandom);
		ir   = 8'($urandom);
		ig   = 8'($urandom);
		ib   = 8'($urandom);
		if (pick < 11) begin
			m = fcch_pkg::MODE_PIXEL;
			if ($urandom_range(0, 9) < 7)
				rgb = sb.palette[$urandom_range(0, fcch_pkg::MAX_COLORS - 1)];
			// mostly small ids, so faces and classes repeat back to back
			if ($urandom_range(0, 9) < 7) begin
				ir = 8'd0;
				ig = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
				ib = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
			end
		end else if (pick < 16) begin
			m = fcch_pkg::MODE_READ;
			if ($urandom_range(0, 1))
				fs = 8'($urandom_range(0, 3));
			if ($urandom_range(0, 3) != 0)
				ci = 5'($urandom_range(0, fcch_pkg::MAX_COLORS));
		end else if (pick < 19) begin
			m = fcch_pkg::MODE_LOAD;
		end else begin
			m = MODE_NONE;
		end
		send_item(m, ci, fs, rgb, ir, ig, ib);
	endtask

	task automatic rand_config();
		logic [8:0] rad, fcs;
		case ($urandom_range(0, 4))
			0: rad = 9'd0;
			1: rad = 9'd1;
			2: rad = 9'($urandom_range(2, 16));
			3: rad = 9'd256;
			default: rad = 9'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: fcs = 9'($urandom_range(0, 8));
			1: fcs = 9'($urandom_range(1, 256));
			2: fcs = 9'd256;
			default: fcs = 9'($urandom);
		endcase
		set_config(rad, 9'($urandom), fcs);
	endtask

	initial begin
		logic [23:0] seed_colors [fcch_pkg::MAX_COLORS];
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_addr    <= fcch_pkg::CFG_RADIX;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		mode        <= MODE_NONE;
		class_index <= '0;
		face_select <= '0;
		red         <= '0;
		green       <= '0;
		blue        <= '0;
		id_red      <= '0;
		id_green    <= '0;
		id_blue     <= '0;
		quiet       = 1'b0;
		gap_rate    = 2;
		stall_rate  = 2;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the counter clearing pass
		@(posedge clk);
		while (!in_ready) @(posedge clk);

		set_config(9'd256, 9'd0, 9'd256);
		send_item(fcch_pkg::MODE_PIXEL, 5'd0, 8'd0, 24'h000000, 8'd0, 8'd0, 8'd0);
		send_item(fcch_pkg::MODE_READ, 5'(fcch_pkg::MAX_COLORS), 8'd0, 24'h0,
			8'd0, 8'd0, 8'd0);
		send_item(MODE_NONE, '1, '1, '1, '1, '1, '1);
		send_item(fcch_pkg::MODE_LOAD, 5'(fcch_pkg::MAX_COLORS), 8'd0, 24'hFFFFFF,
			8'd0, 8'd0, 8'd0);
		send_item(fcch_pkg::MODE_LOAD, 5'd31, 8'd0, 24'hFFFFFF, 8'd0, 8'd0, 8'd0);
		// duplicates in the table: the lowest index has to win
		for (int k = 0; k < fcch_pkg::MAX_COLORS; k++)
			seed_colors[k] = {8'(k), ~8'(k), 8'(k) ^ 8'h5A};
		seed_colors[0]  = 24'h000000;
		seed_colors[1]  = 24'hFFFFFF;
		seed_colors[2]  = 24'h123456;
		seed_colors[3]  = 24'h000000;
		seed_colors[15] = 24'h800001;
		for (int k = 0; k < fcch_pkg::MAX_COLORS; k++)
			send_item(fcch_pkg::MODE_LOAD, 5'(k), 8'd0, seed_colors[k], 8'd0, 8'd0, 8'd0);
		drain();

		set_config(9'd256, 9'h1F0, 9'd256);
		send_item(fcch_pkg::MODE_PIXEL, 5'd0, 8'd0, 24'h000000, 8'd0, 8'd0, 8'd255);
		send_item(fcch_pkg::MODE_PIXEL, 5'd0, 8'd0, 24'hFFFFFF, 8'd255, 8'd255, 8'd255);
		send_item(fcch_pkg::MODE_PIXEL, 5'd0, 8'd0, 24'h800001, 8'd0, 8'd1, 8'd0);
		send_item(fcch_pkg::MODE_PIXEL, 5'd0, 8'd0, 24'h123456, 8'd0, 8'd0, 8'd255);
		send_item(fcch_pkg::MODE_READ, 5'd0, 8'd255, 24'h0, 8'd0, 8'd0, 8'd0);
		send_item(fcch_pkg::MODE_READ, 5'd17, 8'd255, 24'h0, 8'd0, 8'd0, 8'd0);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			gap_rate   = $urandom_range(0, 4);
			stall_rate = $urandom_range(0, 4);
			case (phase)
				0: set_config(9'd0, 9'd31, 9'd511);
				1: set_config(9'd511, 9'd16, 9'd1);
				2: set_config(9'd1, 9'd0, 9'd0);
				3: set_config(9'd256, 9'd1, 9'd256);
				default: rand_config();
			endcase
			// the last phase runs with no idling on either side
			if (phase == 9)
				quiet = 1'b1;
			repeat ((phase == 9) ? 100 : 50) rand_item();
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
